[rtl/scpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-chance replacement package
// Shared constants, controller state type and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package scpr_pkg;

  // Default sizing of the frame table and of a page number.
  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 16;

  // Frame count register: width and value after reset.
  localparam int unsigned   CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Width of the saturating fault counter.
  localparam int unsigned FAULT_W = 32;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } scpr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the page and settle the hand
    logic hit_commit;  // mark the hit frame and publish the result
    logic sweep_step;  // examine the frame under the hand
  } scpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;      // page is resident among the frames in use
    logic ref_set;  // reference bit under the hand is set
  } scpr_sts_t;

endpackage

[rtl/second_chance_page_replacement_unit.sv]
`timescale 1ns / 1ps
// Operation: a hit is found by a parallel lookup; a miss sweeps the hand one
//   frame per cycle, clearing set reference bits, until a clear bit is found.
// Busy: a new reference is taken only once the previous one is finished.
// Reset: all frames empty, reference bits clear, hand and fault count zero,
//   frame count 16; no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// Second-chance page replacement unit
// Top level joining the sequencing controller to the frame-table datapath.
// ----------------------------------------------------------------------------
module second_chance_page_replacement_unit
  import scpr_pkg::*;
#(
  parameter  int unsigned FRAMES    = FRAMES_DEF,
  parameter  int unsigned PAGE_BITS = PAGE_BITS_DEF,
  localparam int unsigned FI_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [PAGE_BITS-1:0] page_number_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [FI_W-1:0]      frame_index_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  scpr_cmd_t cmd;
  scpr_sts_t sts;

  // Sequencer.
  scpr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Frame table and result beat.
  scpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .page_number_i   (page_number_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule

[rtl/scpr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-chance replacement controller
// Sequences one reference: capture, parallel lookup, then on a miss a sweep
// of the hand one frame per cycle until a clear reference bit is found.
// ----------------------------------------------------------------------------
module scpr_ctrl
  import scpr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  scpr_sts_t sts_i,
  output scpr_cmd_t cmd_o,
  output logic      busy_o
);

  scpr_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts_i.hit) begin
          cmd_o.hit_commit = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // A clear bit ends the sweep; the datapath places the page there.
        cmd_o.sweep_step = 1'b1;
        if (!sts_i.ref_set) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/scpr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-chance replacement datapath
// Holds the frame table, reference bits, hand, fault counter and frame
// count register, and registers each result beat for one cycle.
// ----------------------------------------------------------------------------
module scpr_dp
  import scpr_pkg::*;
#(
  parameter  int unsigned FRAMES    = FRAMES_DEF,
  parameter  int unsigned PAGE_BITS = PAGE_BITS_DEF,
  localparam int unsigned FI_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  scpr_cmd_t            cmd_i,
  output scpr_sts_t            sts_o,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [FI_W-1:0]      frame_index_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  // Width of a frame count (1 .. FRAMES) and of the clamp arithmetic.
  localparam int unsigned NW = $clog2(FRAMES + 1);
  localparam int unsigned CW = (NW > CFG_W) ? NW : CFG_W;

  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [FRAMES-1:0]    ref_q;
  logic [FI_W-1:0]      hand_q;
  logic [FAULT_W-1:0]   fault_q, fault_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [NW-1:0]        n_q, n_d;
  logic [PAGE_BITS-1:0] page_q;
  logic                 done_q;

  logic                 hit_q;
  logic [FI_W-1:0]      idx_q;
  logic                 ev_valid_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic [FAULT_W-1:0]   total_q;

  logic [FRAMES-1:0]    match;
  logic [FI_W-1:0]      hit_idx;
  logic [NW-1:0]        hand_inc;
  logic [FI_W-1:0]      hand_nx;
  logic                 place;

  // Frame count clamped to 1 .. FRAMES.
  always_comb begin
    logic [CW-1:0] cfg_ext;
    cfg_ext = CW'(cfg_q);
    if (cfg_ext == '0) begin
      n_d = NW'(1);
    end else if (cfg_ext > CW'(FRAMES)) begin
      n_d = NW'(FRAMES);
    end else begin
      n_d = NW'(cfg_ext);
    end
  end

  // Parallel lookup over the frames in use; the lowest match wins.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = valid_q[i] && (frame_page_q[i] == page_q) && (NW'(i) < n_q);
    end
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = FI_W'(i);
      end
    end
  end

  // Hand advance with wrap at the frame count.
  assign hand_inc = NW'(hand_q) + NW'(1);
  assign hand_nx  = (hand_inc >= n_q) ? '0 : FI_W'(hand_inc);

  // Saturating fault count after a miss.
  assign fault_d = (&fault_q) ? fault_q : fault_q + FAULT_W'(1);

  assign sts_o.hit     = |match;
  assign sts_o.ref_set = ref_q[hand_q];

  // The sweep has found a clear bit: the page goes under the hand.
  assign place = cmd_i.sweep_step && !ref_q[hand_q];

  // Control state and replacement bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q   <= '0;
      hand_q  <= '0;
      fault_q <= '0;
      cfg_q   <= CFG_RESET;
      n_q     <= NW'(FRAMES);
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.hit_commit || place;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        n_q <= n_d;
        // The hand restarts at frame 0 when the new frame count no longer covers it.
        if (NW'(hand_q) >= n_d) begin
          hand_q <= '0;
        end
      end
      if (cmd_i.hit_commit) begin
        ref_q[hit_idx] <= 1'b1;
      end
      if (cmd_i.sweep_step) begin
        ref_q[hand_q] <= 1'b0;
        hand_q        <= hand_nx;
      end
      if (place) begin
        valid_q[hand_q] <= 1'b1;
        fault_q         <= fault_d;
      end
    end
  end

  // Frame table, captured page and result beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= page_number_i;
    end
    if (cmd_i.hit_commit) begin
      hit_q      <= 1'b1;
      idx_q      <= hit_idx;
      ev_valid_q <= 1'b0;
      ev_page_q  <= '0;
      total_q    <= fault_q;
    end
    if (place) begin
      frame_page_q[hand_q] <= page_q;
      hit_q      <= 1'b0;
      idx_q      <= hand_q;
      ev_valid_q <= valid_q[hand_q];
      ev_page_q  <= valid_q[hand_q] ? frame_page_q[hand_q] : '0;
      total_q    <= fault_d;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = idx_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = total_q;

  // After every result the hand points inside the frames in use.
  a_hand_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (NW'(hand_q) < n_q))
    else $error("hand outside the frames in use after a result");

  // A hit beat names a valid frame whose reference bit is now set.
  a_hit_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hit_q) |-> (valid_q[idx_q] && ref_q[idx_q]))
    else $error("hit frame not valid or reference bit not set");

  // A fault beat names the frame now holding the page with a clear bit.
  a_fault_places: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !hit_q) |->
      (valid_q[idx_q] && !ref_q[idx_q] && (frame_page_q[idx_q] == page_q)))
    else $error("faulted page not placed in the reported frame");

  // The fault counter never goes backwards.
  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(fault_q) |-> (fault_q == $past(fault_q) + FAULT_W'(1)))
    else $error("fault counter moved by other than one");

endmodule

[verif/second_chance_page_replacement_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-chance page replacement unit testbench
// Drives page references and frame-count writes into the unit. A directed
// table comes first, then phases of random references drawn mostly from
// small page pools so that hits, sweeps and evictions are frequent. Every
// result beat is checked against a clock-replacement predictor kept in
// the testbench, or against the written-out expectation of a directed row.
// ----------------------------------------------------------------------------
module second_chance_page_replacement_unit_test;
  import scpr_pkg::*;

  localparam int unsigned N_FRAMES    = 16;
  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned FI_W        = 4;
  localparam int unsigned TOTAL_REFS  = 1050;
  localparam int unsigned CALM_FROM   = 950;   // no random hold-offs from here on
  localparam int unsigned SETTLE_CYC  = 24;    // longer than the slowest miss
  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct packed {
    logic              hit;
    logic [FI_W-1:0]   frame_index;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } lookup_result_t;

  typedef enum logic {
    ROW_FRAMES,
    ROW_PAGE
  } row_kind_e;

  typedef struct {
    row_kind_e      kind;
    logic [15:0]    value;
    bit             typed;
    lookup_result_t want;
  } stim_row_t;

  // Ports of the unit.
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i   = '0;
  logic               start_i       = 1'b0;
  logic               busy_o;
  logic [PAGE_W-1:0]  page_number_i = '0;
  logic               done_o;
  logic               hit_o;
  logic [FI_W-1:0]    frame_index_o;
  logic               evicted_valid_o;
  logic [PAGE_W-1:0]  evicted_page_o;
  logic [FAULT_W-1:0] fault_total_o;

  // Predictor state: a private copy of the frame table and register.
  logic [PAGE_W-1:0]  tbl_page  [N_FRAMES];
  bit                 tbl_valid [N_FRAMES];
  bit                 tbl_ref   [N_FRAMES];
  int unsigned        hand_pos;
  logic [FAULT_W-1:0] fault_cnt;
  logic [CFG_W-1:0]   frames_reg;

  lookup_result_t lookup_results_q[$];
  stim_row_t      stim_rows[$];
  logic [15:0]    page_pool[$];

  int unsigned refs_sent;
  int unsigned hit_cnt;
  int unsigned evict_cnt;
  int unsigned frames_writes;
  int unsigned err_cnt;
  int unsigned stall_cnt;

  second_chance_page_replacement_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_number_i  (page_number_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o)
  );

  always #4 clk_i = ~clk_i;

  // Clock replacement for one reference: search, else sweep and place.
  function automatic lookup_result_t clock_lookup(logic [PAGE_W-1:0] page);
    lookup_result_t r;
    int unsigned    n;
    int unsigned    slot;
    int             i;
    bit             found;
    r     = '0;
    found = 1'b0;
    n     = frames_reg;
    if (n == 0) n = 1;
    if (n > N_FRAMES) n = N_FRAMES;
    if (hand_pos >= n) hand_pos = 0;

    for (i = 0; i < n; i++) begin
      if (!found && tbl_valid[i] && tbl_page[i] == page) begin
        found         = 1'b1;
        tbl_ref[i]    = 1'b1;
        r.hit         = 1'b1;
        r.frame_index = FI_W'(i);
      end
    end
    if (found) begin
      r.fault_total = fault_cnt;
      return r;
    end

    // Give set frames their second chance on the way round.
    slot = hand_pos;
    for (i = 0; i <= n; i++) begin
      if (!tbl_ref[slot]) break;
      tbl_ref[slot] = 1'b0;
      slot = (slot + 1 >= n) ? 0 : slot + 1;
    end

    r.evicted_valid = tbl_valid[slot];
    r.evicted_page  = tbl_valid[slot] ? tbl_page[slot] : '0;
    tbl_page[slot]  = page;
    tbl_valid[slot] = 1'b1;
    tbl_ref[slot]   = 1'b0;
    hand_pos        = (slot + 1 >= n) ? 0 : slot + 1;
    if (fault_cnt != '1) fault_cnt++;
    r.frame_index = FI_W'(slot);
    r.fault_total = fault_cnt;
    return r;
  endfunction

  function automatic void add_frames_row(logic [CFG_W-1:0] v);
    stim_row_t row;
    row       = '{kind: ROW_FRAMES, value: '0, typed: 1'b0, want: '0};
    row.kind  = ROW_FRAMES;
    row.value = 16'(v);
    stim_rows.push_back(row);
  endfunction

  function automatic void add_page_row(logic [15:0] p);
    stim_row_t row;
    row       = '{kind: ROW_PAGE, value: '0, typed: 1'b0, want: '0};
    row.kind  = ROW_PAGE;
    row.value = p;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_known_row(logic [15:0] p, lookup_result_t want);
    stim_row_t row;
    row       = '{kind: ROW_PAGE, value: '0, typed: 1'b0, want: '0};
    row.kind  = ROW_PAGE;
    row.value = p;
    row.typed = 1'b1;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  // One reference beat; the expectation is queued at the accepting edge.
  task automatic send_page(logic [15:0] p, bit typed, lookup_result_t want);
    lookup_result_t r;
    start_i       <= 1'b1;
    page_number_i <= p;
    do @(posedge clk_i); while (busy_o);
    r = clock_lookup(p);
    if (typed) r = want;
    if (r.hit) hit_cnt++;
    if (r.evicted_valid) evict_cnt++;
    lookup_results_q.push_back(r);
    refs_sent++;
  endtask

  task automatic hold_off(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result beat.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (lookup_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Frame-count writes happen only with the unit idle.
  task automatic write_frames(logic [CFG_W-1:0] v);
    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    frames_reg  = v;
    frames_writes++;
    @(posedge clk_i);
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_ni && done_o) begin
      got = '{hit_o, frame_index_o, evicted_valid_o, evicted_page_o, fault_total_o};
      if (lookup_results_q.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                 $time, got.hit, got.frame_index, got.evicted_valid,
                 got.evicted_page, got.fault_total);
        err_cnt++;
      end else begin
        want = lookup_results_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                   $time, want.hit, want.frame_index, want.evicted_valid,
                   want.evicted_page, want.fault_total);
          $display("%0t:          actual   hit=%0d frame=%0d ev=%0d/%h faults=%0d",
                   $time, got.hit, got.frame_index, got.evicted_valid,
                   got.evicted_page, got.fault_total);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with neither an input beat nor a result beat.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, lookup_results_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    lookup_result_t none;
    lookup_result_t r;
    logic [CFG_W-1:0] fr;
    int unsigned n_eff;
    int unsigned burst;
    int unsigned k;
    bit          gaps_on;
    bit          paused;
    logic [15:0] p;

    // Predictor reset state.
    for (int i = 0; i < N_FRAMES; i++) begin
      tbl_page[i]  = '0;
      tbl_valid[i] = 1'b0;
      tbl_ref[i]   = 1'b0;
    end
    hand_pos      = 0;
    fault_cnt     = '0;
    frames_reg    = CFG_RESET;
    refs_sent     = 0;
    hit_cnt       = 0;
    evict_cnt     = 0;
    frames_writes = 0;
    err_cnt       = 0;
    stall_cnt     = 0;
    none          = '0;
    paused        = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table. From empty with one frame the results are obvious.
    add_frames_row(5'd1);
    r = '0; r.frame_index = FI_W'(0); r.fault_total = FAULT_W'(1);
    add_known_row(16'h0000, r);
    r = '0; r.hit = 1'b1; r.frame_index = FI_W'(0); r.fault_total = FAULT_W'(1);
    add_known_row(16'h0000, r);
    r = '0; r.frame_index = FI_W'(0); r.evicted_valid = 1'b1;
    r.fault_total = FAULT_W'(2);
    add_known_row(16'hFFFF, r);
    // Full table, fill and hit a few frames.
    add_frames_row(5'd16);
    add_page_row(16'h1234);
    add_page_row(16'hFFFF);
    add_page_row(16'hAAAA);
    add_page_row(16'h5555);
    add_page_row(16'h1234);
    add_page_row(16'hFFFF);
    // Shrink below the hand: the hand restarts at frame 0 and sweeps round.
    add_frames_row(5'd2);
    add_page_row(16'h0001);
    add_page_row(16'hAAAA);
    // Grow again: a page now held twice hits on the lower frame.
    add_frames_row(5'd4);
    add_page_row(16'hAAAA);
    add_page_row(16'h5555);
    add_page_row(16'h0001);
    add_page_row(16'h8000);
    // Counts above the table size and of zero are clamped.
    add_frames_row(5'd17);
    add_page_row(16'h0001);
    add_frames_row(5'd0);
    add_page_row(16'h8000);
    add_frames_row(5'd31);
    add_page_row(16'h8000);
    add_page_row(16'h7FFF);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_FRAMES)
        write_frames(CFG_W'(stim_rows[i].value));
      else
        send_page(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].want);
    end

    // Random phases: a new frame count, then references from a small pool.
    while (refs_sent < TOTAL_REFS) begin
      case ($urandom_range(0, 7))
        0:       fr = 5'd0;
        1:       fr = 5'd1;
        2:       fr = 5'd16;
        3:       fr = 5'd31;
        4:       fr = CFG_W'($urandom_range(17, 31));
        default: fr = CFG_W'($urandom_range(1, 16));
      endcase
      write_frames(fr);
      n_eff = (fr == 0) ? 1 : ((fr > N_FRAMES) ? N_FRAMES : fr);

      page_pool.delete();
      k = n_eff + $urandom_range(0, 4);
      for (int i = 0; i < k; i++) page_pool.push_back(16'($urandom));

      burst   = $urandom_range(15, 60);
      gaps_on = $urandom_range(0, 1);
      for (int i = 0; i < burst && refs_sent < TOTAL_REFS; i++) begin
        case ($urandom_range(0, 9))
          0:       p = 16'($urandom);
          1:       p = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
          default: p = page_pool[$urandom_range(0, page_pool.size() - 1)];
        endcase
        if (gaps_on && refs_sent < CALM_FROM && $urandom_range(0, 4) == 0)
          hold_off($urandom_range(1, 15));
        send_page(p, 1'b0, none);
        // Once, mid-phase, let the unit run dry before carrying on.
        if (!paused && refs_sent > 400) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Covered %0d references (%0d hits, %0d evictions) over %0d frame-count writes.",
             refs_sent, hit_cnt, evict_cnt, frames_writes);
    $display("Frame counts included zero, one, full and above-full settings.");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches recorded", err_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
